@@ hdl/assert_macros.svh @@
// Assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

@@ hdl/isc_pkg.sv @@
package isc_pkg;

  typedef struct packed {
    logic       mode;
    logic [9:0] coord_x;
    logic [9:0] coord_y;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_item_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_ASPECT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BILINEAR    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE  = 3'd6;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef enum logic [3:0] {
    ST_DIV_LOAD_H,
    ST_DIV_H,
    ST_DIV_LOAD_V,
    ST_DIV_V,
    ST_ASPECT,
    ST_IDLE,
    ST_MUL_X,
    ST_SPLIT_X,
    ST_MUL_Y,
    ST_SPLIT_Y,
    ST_NEIGH,
    ST_RD_ADDR,
    ST_RD_CAP,
    ST_BL_MUL,
    ST_BL_ACC,
    ST_OUT
  } state_t;

endpackage

@@ hdl/image_scaler_nearest_bilinear.sv @@
// Channel   Handshake            Payload
// in        in_valid/in_ready    in_item  (load or sample item)
// out       out_valid/out_ready  out_item (sampled RGB)
// cfg       cfg_we               cfg_index, cfg_data (write only)
//
// Load item: written straight into the frame memory.
// Sample item: the shared multiplier does both coordinate products and six
//   blend products per colour, and the single-port frame memory reads each
//   neighbour in an address state and a capture state.
// Reset and every register write rerun the step division, one quotient bit a
//   cycle; in_ready is low meanwhile.
// Reset is synchronous; the frame memory is not cleared.
// A finished result waits in the output register; the next item is taken
//   while it waits, and a sample only stalls when it needs that register.
`include "assert_macros.svh"

module image_scaler_nearest_bilinear import isc_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int FRAC_BITS      = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // coordinate and size widths
  localparam int XW  = $clog2(MAX_SRC_WIDTH);
  localparam int YW  = $clog2(MAX_SRC_HEIGHT);
  localparam int SWW = $clog2(MAX_SRC_WIDTH + 1);
  localparam int SHW = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int SMW = (SWW > SHW) ? SWW : SHW;
  localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW  = $clog2(DEPTH);
  // divider: dividend is source size shifted up by the fraction
  localparam int DW  = SMW + FRAC_BITS;
  localparam int DCW = $clog2(DW + 1);
  // shared multiplier: a is 32 bits (step, pixel channel or partial blend), b the short factor
  localparam int BW  = (FRAC_BITS + 1 > 10) ? FRAC_BITS + 1 : 10;
  localparam int PW  = 32 + BW;
  localparam int TW  = 8 + FRAC_BITS;
  localparam int OW  = 8 + 2 * FRAC_BITS;

  // configuration registers
  logic [8:0]  src_width, src_height;
  logic [10:0] dst_width, dst_height;
  logic        keep_aspect, bilinear_enable, color_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width       <= 9'd256;
      src_height      <= 9'd256;
      dst_width       <= 11'd256;
      dst_height      <= 11'd256;
      keep_aspect     <= 1'b0;
      bilinear_enable <= 1'b0;
      color_mode      <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH:   src_width       <= cfg_data[8:0];
        REG_SRC_HEIGHT:  src_height      <= cfg_data[8:0];
        REG_DST_WIDTH:   dst_width       <= cfg_data;
        REG_DST_HEIGHT:  dst_height      <= cfg_data;
        REG_KEEP_ASPECT: keep_aspect     <= cfg_data[0];
        REG_BILINEAR:    bilinear_enable <= cfg_data[0];
        REG_COLOR_MODE:  color_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective sizes: zero acts as one, source clamped to the store
  logic [SWW-1:0] w_eff;
  logic [SHW-1:0] h_eff;
  logic [10:0]    dw_eff, dh_eff;

  always_comb begin
    if (src_width == 9'd0)                     w_eff = SWW'(1);
    else if (32'(src_width) > MAX_SRC_WIDTH)   w_eff = SWW'(MAX_SRC_WIDTH);
    else                                       w_eff = SWW'(src_width);
    if (src_height == 9'd0)                    h_eff = SHW'(1);
    else if (32'(src_height) > MAX_SRC_HEIGHT) h_eff = SHW'(MAX_SRC_HEIGHT);
    else                                       h_eff = SHW'(src_height);
    dw_eff = (dst_width == 11'd0) ? 11'd1 : dst_width;
    dh_eff = (dst_height == 11'd0) ? 11'd1 : dst_height;
  end

  function automatic logic [31:0] sat32(input logic [DW-1:0] q);
    sat32 = (64'(q) > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : 32'(q);
  endfunction

  function automatic logic [7:0] chan_of(input logic [23:0] p, input logic [1:0] ch,
                                         input logic color);
    logic [7:0] v;
    v = p[23:16];
    if (color) begin
      case (ch)
        2'd1:    v = p[15:8];
        2'd2:    v = p[7:0];
        default: v = p[23:16];
      endcase
    end
    chan_of = v;
  endfunction

  state_t state, state_next;

  // datapath registers
  logic [DW-1:0]    dq;
  logic [10:0]      rem, dvs;
  logic [DCW-1:0]   div_cnt;
  logic [31:0]      h_step, v_step, h_raw;
  logic [9:0]       cx, cy;
  logic [PW-1:0]    prod;
  logic [XW-1:0]    x1, x2;
  logic [YW-1:0]    y1, y2;
  logic [FRAC_BITS-1:0] tx, ty;
  logic [1:0]       rd_n, ch;
  logic [2:0]       k;
  logic [23:0]      pix [4];
  logic [TW-1:0]    acc_top, acc_bot;
  logic [OW-1:0]    acc_out;
  logic [7:0]       res [3];

  // frame memory
  logic [23:0]      mem [DEPTH];
  logic [23:0]      mem_q;
  logic             mem_we;
  logic [AW-1:0]    mem_addr;
  logic [23:0]      mem_wdata;

  // shared multiplier operands
  logic [31:0]      mul_a;
  logic [BW-1:0]    mul_b;

  // divider step
  logic [11:0]      rem_sh;
  logic             div_last;
  logic             accept, out_free;

  assign rem_sh   = {rem, dq[DW-1]};
  assign div_last = (div_cnt == DCW'(DW - 1));
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_DIV_LOAD_H: state_next = ST_DIV_H;
      ST_DIV_H:      if (div_last) state_next = ST_DIV_LOAD_V;
      ST_DIV_LOAD_V: state_next = ST_DIV_V;
      ST_DIV_V:      if (div_last) state_next = ST_ASPECT;
      ST_ASPECT:     state_next = ST_IDLE;
      ST_IDLE:       if (in_valid && in_item.mode == MODE_SAMPLE) state_next = ST_MUL_X;
      ST_MUL_X:      state_next = ST_SPLIT_X;
      ST_SPLIT_X:    state_next = ST_MUL_Y;
      ST_MUL_Y:      state_next = ST_SPLIT_Y;
      ST_SPLIT_Y:    state_next = ST_NEIGH;
      ST_NEIGH:      state_next = ST_RD_ADDR;
      ST_RD_ADDR:    state_next = ST_RD_CAP;
      ST_RD_CAP: begin
        if (rd_n != 2'd3)         state_next = ST_RD_ADDR;
        else if (bilinear_enable) state_next = ST_BL_MUL;
        else                      state_next = ST_OUT;
      end
      ST_BL_MUL:     state_next = ST_BL_ACC;
      ST_BL_ACC:     state_next = (k == 3'd5 && ch == 2'd2) ? ST_OUT : ST_BL_MUL;
      ST_OUT:        if (out_free) state_next = ST_IDLE;
    endcase
    // any register write reruns the step division
    if (cfg_we) state_next = ST_DIV_LOAD_H;
  end

  // control outputs, memory port and multiplier operand select
  always_comb begin
    logic [XW-1:0] ax;
    logic [YW-1:0] ay;
    logic [BW-1:0] one_b;
    in_ready  = (state == ST_IDLE);
    mem_we    = 1'b0;
    mem_wdata = color_mode ? {in_item.in_red, in_item.in_green, in_item.in_blue}
                           : {in_item.in_red, in_item.in_red, in_item.in_red};
    ax = x1;
    ay = y1;
    if (state == ST_IDLE) begin
      ax = XW'(in_item.coord_x);
      ay = YW'(in_item.coord_y);
      mem_we = accept && in_item.mode == MODE_LOAD &&
               32'(in_item.coord_x) < MAX_SRC_WIDTH &&
               32'(in_item.coord_y) < MAX_SRC_HEIGHT;
    end else begin
      if (rd_n[0]) ax = x2;
      if (rd_n[1]) ay = y2;
    end
    mem_addr = AW'(ay) * AW'(MAX_SRC_WIDTH) + AW'(ax);

    one_b = BW'(1) << FRAC_BITS;
    mul_a = h_step;
    mul_b = BW'(cx);
    if (state == ST_MUL_Y) begin
      mul_a = v_step;
      mul_b = BW'(cy);
    end else if (state == ST_BL_MUL) begin
      case (k)
        3'd0:    begin mul_a = 32'(chan_of(pix[0], ch, color_mode)); mul_b = one_b - BW'(tx); end
        3'd1:    begin mul_a = 32'(chan_of(pix[1], ch, color_mode)); mul_b = BW'(tx); end
        3'd2:    begin mul_a = 32'(chan_of(pix[2], ch, color_mode)); mul_b = one_b - BW'(tx); end
        3'd3:    begin mul_a = 32'(chan_of(pix[3], ch, color_mode)); mul_b = BW'(tx); end
        3'd4:    begin mul_a = 32'(acc_top); mul_b = one_b - BW'(ty); end
        default: begin mul_a = 32'(acc_bot); mul_b = BW'(ty); end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_q <= mem[mem_addr];
  end

  // the one multiplier, registered
  always_ff @(posedge clk) begin
    prod <= PW'(mul_a) * PW'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_DIV_LOAD_H;
    else     state <= state_next;
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    logic [PW-1:0] ip;
    ip = prod >> FRAC_BITS;
    case (state)
      ST_DIV_LOAD_H: begin
        dq      <= DW'(w_eff) << FRAC_BITS;
        rem     <= '0;
        dvs     <= dw_eff;
        div_cnt <= '0;
      end
      ST_DIV_LOAD_V: begin
        h_raw   <= sat32(dq);
        dq      <= DW'(h_eff) << FRAC_BITS;
        rem     <= '0;
        dvs     <= dh_eff;
        div_cnt <= '0;
      end
      ST_DIV_H, ST_DIV_V: begin
        div_cnt <= div_cnt + DCW'(1);
        if (rem_sh >= {1'b0, dvs}) begin
          rem <= 11'(rem_sh - {1'b0, dvs});
          dq  <= {dq[DW-2:0], 1'b1};
        end else begin
          rem <= rem_sh[10:0];
          dq  <= {dq[DW-2:0], 1'b0};
        end
      end
      ST_ASPECT: begin
        if (keep_aspect) begin
          h_step <= (h_raw < sat32(dq)) ? sat32(dq) : h_raw;
          v_step <= (h_raw < sat32(dq)) ? sat32(dq) : h_raw;
        end else begin
          h_step <= h_raw;
          v_step <= sat32(dq);
        end
      end
      ST_IDLE: begin
        cx <= in_item.coord_x;
        cy <= in_item.coord_y;
      end
      ST_SPLIT_X: begin
        if (ip >= PW'(w_eff)) begin
          x1 <= XW'(w_eff - SWW'(1));
          tx <= '0;
        end else begin
          x1 <= XW'(ip);
          tx <= prod[FRAC_BITS-1:0];
        end
      end
      ST_SPLIT_Y: begin
        if (ip >= PW'(h_eff)) begin
          y1 <= YW'(h_eff - SHW'(1));
          ty <= '0;
        end else begin
          y1 <= YW'(ip);
          ty <= prod[FRAC_BITS-1:0];
        end
      end
      ST_NEIGH: begin
        // right and bottom neighbours clamp to the edge
        x2   <= (SWW'(x1) + SWW'(1) >= w_eff) ? XW'(w_eff - SWW'(1)) : x1 + XW'(1);
        y2   <= (SHW'(y1) + SHW'(1) >= h_eff) ? YW'(h_eff - SHW'(1)) : y1 + YW'(1);
        rd_n <= 2'd0;
        k    <= '0;
        ch   <= '0;
      end
      ST_RD_CAP: begin
        pix[rd_n] <= mem_q;
        rd_n      <= rd_n + 2'd1;
      end
      ST_BL_ACC: begin
        case (k)
          3'd0: acc_top <= TW'(prod);
          3'd1: acc_top <= acc_top + TW'(prod);
          3'd2: acc_bot <= TW'(prod);
          3'd3: acc_bot <= acc_bot + TW'(prod);
          3'd4: acc_out <= OW'(prod);
          default: res[ch] <= 8'((acc_out + OW'(prod)) >> (2 * FRAC_BITS));
        endcase
        if (k == 3'd5) begin
          k  <= '0;
          ch <= ch + 2'd1;
        end else begin
          k <= k + 3'd1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      if (bilinear_enable) begin
        out_item <= '{out_red: res[0], out_green: res[1], out_blue: res[2]};
      end else begin
        out_item <= '{out_red:   chan_of(pix[0], 2'd0, color_mode),
                      out_green: chan_of(pix[0], 2'd1, color_mode),
                      out_blue:  chan_of(pix[0], 2'd2, color_mode)};
      end
    end
  end

  `ASSERT_HOLDS(a_sample_busy, (accept && in_item.mode == MODE_SAMPLE) |=> !in_ready, "sample item did not hold off input")
  `ASSERT_HOLDS(a_cfg_recompute, cfg_we |=> !in_ready, "input taken while steps recomputed")
  `ASSERT_NEVER(a_pos_in_frame, (state == ST_RD_ADDR) && (SWW'(x2) >= w_eff || SHW'(y2) >= h_eff), "neighbour outside source frame")

endmodule
